/* hw/rtl/cnm_pkg.sv */
// shared types and constants for the cross neighbourhood mean blur
`timescale 1ns / 1ps

package cnm_pkg;

    // fixed widths of the result indexes and the size register
    localparam int IDX_W      = 10;
    localparam int CFG_W      = 11;
    localparam int RESET_SIZE = 8;

    // neighbourhood count, 1 to 5
    localparam int CNT_W = 3;

    // three line store rows, one slot per row
    localparam int ROWS   = 3;
    localparam int SLOT_W = 2;

    typedef logic [SLOT_W-1:0] slot_t;

    // position of an item inside the image, taken when it is accepted
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
    } pos_flags_t;

    // results an item still owes, in output order
    typedef struct packed {
        logic upper;
        logic row_left;
        logic corner;
    } res_mask_t;

endpackage

/* hw/rtl/cnm_line_store.sv */
// three-row line store with one write port and two registered read ports
`timescale 1ns / 1ps

module cnm_line_store
    import cnm_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_SIZE   = 1024,
    parameter int COL_W      = 10
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  slot_t                 wr_slot,
    input  logic [COL_W-1:0]      wr_col,
    input  logic [PIXEL_BITS-1:0] wr_data,
    input  logic                  rd_en,
    input  slot_t                 rd_slot_a,
    input  slot_t                 rd_slot_b,
    input  logic [COL_W-1:0]      rd_col,
    output logic [PIXEL_BITS-1:0] rd_data_a,
    output logic [PIXEL_BITS-1:0] rd_data_b
);

    logic [PIXEL_BITS-1:0] store_mem [ROWS][MAX_SIZE];
    logic [PIXEL_BITS-1:0] rd_data_a_reg;
    logic [PIXEL_BITS-1:0] rd_data_b_reg;

    // write of the incoming pixel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_slot][wr_col] <= wr_data;
        end
    end

    // prefetch of the next column of the two rows above
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= store_mem[rd_slot_a][rd_col];
            rd_data_b_reg <= store_mem[rd_slot_b][rd_col];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* hw/rtl/cnm_window.sv */
// current item, 3x3 cross window registers and per-item result sequencer
`timescale 1ns / 1ps

module cnm_window
    import cnm_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int COL_W      = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // item entering the window stage
    input  logic                    accept,
    input  logic [PIXEL_BITS-1:0]   pixel,
    input  pos_flags_t              flags,
    input  logic [COL_W-1:0]        row,
    input  logic [COL_W-1:0]        col,
    input  res_mask_t               pend,
    // line store data for the next column: row above and two rows above
    input  logic [PIXEL_BITS-1:0]   up_next,
    input  logic [PIXEL_BITS-1:0]   upup_next,
    output logic                    in_stall,
    // sum stage towards the divider
    input  logic                    d_ready,
    output logic                    d_valid,
    output logic [PIXEL_BITS+2:0]   d_sum,
    output logic [CNT_W-1:0]        d_cnt,
    output logic [IDX_W-1:0]        d_row,
    output logic [IDX_W-1:0]        d_col,
    output logic                    d_last
);

    localparam int SUM_W = PIXEL_BITS + 3;

    // current item
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    res_mask_t             s1_pend_reg;
    res_mask_t             s1_pend_next;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    pos_flags_t            s1_flags_reg;
    logic [COL_W-1:0]      s1_row_reg;
    logic [COL_W-1:0]      s1_col_reg;

    // neighbours of the current item
    logic [PIXEL_BITS-1:0] up_c_reg;
    logic [PIXEL_BITS-1:0] up_l_reg;
    logic [PIXEL_BITS-1:0] upup_c_reg;
    logic [PIXEL_BITS-1:0] cur_l_reg;
    logic [PIXEL_BITS-1:0] cur_ll_reg;

    // sum stage
    logic                  d_valid_reg;
    logic                  d_valid_next;
    logic [SUM_W-1:0]      d_sum_reg;
    logic [CNT_W-1:0]      d_cnt_reg;
    logic [IDX_W-1:0]      d_row_reg;
    logic [IDX_W-1:0]      d_col_reg;
    logic                  d_last_reg;

    logic                  d_free;
    logic                  d_take;
    logic                  retire;
    res_mask_t             pend_after;
    logic [SUM_W-1:0]      sum_up;
    logic [SUM_W-1:0]      sum_left;
    logic [SUM_W-1:0]      sum_corner;
    logic [CNT_W-1:0]      cnt_up;
    logic [CNT_W-1:0]      cnt_left;
    logic [CNT_W-1:0]      cnt_corner;
    logic [COL_W-1:0]      row_m1;
    logic [COL_W-1:0]      col_m1;
    logic [SUM_W-1:0]      sel_sum;
    logic [CNT_W-1:0]      sel_cnt;
    logic [IDX_W-1:0]      sel_row;
    logic [IDX_W-1:0]      sel_col;

    assign row_m1 = s1_row_reg - COL_W'(1);
    assign col_m1 = s1_col_reg - COL_W'(1);

    // sums of the three result kinds
    always_comb
    begin
        // result for the pixel above the current one
        sum_up = SUM_W'(up_c_reg) + SUM_W'(s1_pix_reg)
               + (s1_flags_reg.row_ge2  ? SUM_W'(upup_c_reg) : '0)
               + (s1_flags_reg.col_ge1  ? SUM_W'(up_l_reg)   : '0)
               + (!s1_flags_reg.col_last ? SUM_W'(up_next)   : '0);
        cnt_up = CNT_W'(2) + CNT_W'(s1_flags_reg.row_ge2) + CNT_W'(s1_flags_reg.col_ge1)
               + CNT_W'(!s1_flags_reg.col_last);

        // last row: result for the pixel to the left
        sum_left = SUM_W'(cur_l_reg) + SUM_W'(s1_pix_reg)
                 + (s1_flags_reg.row_ge1 ? SUM_W'(up_l_reg)   : '0)
                 + (s1_flags_reg.col_ge2 ? SUM_W'(cur_ll_reg) : '0);
        cnt_left = CNT_W'(2) + CNT_W'(s1_flags_reg.row_ge1) + CNT_W'(s1_flags_reg.col_ge2);

        // bottom right corner
        sum_corner = SUM_W'(s1_pix_reg)
                   + (s1_flags_reg.row_ge1 ? SUM_W'(up_c_reg)  : '0)
                   + (s1_flags_reg.col_ge1 ? SUM_W'(cur_l_reg) : '0);
        cnt_corner = CNT_W'(1) + CNT_W'(s1_flags_reg.row_ge1) + CNT_W'(s1_flags_reg.col_ge1);
    end

    // pick the oldest owed result
    always_comb
    begin
        pend_after = s1_pend_reg;
        priority if (s1_pend_reg.upper)
        begin
            sel_sum          = sum_up;
            sel_cnt          = cnt_up;
            sel_row          = IDX_W'(row_m1);
            sel_col          = IDX_W'(s1_col_reg);
            pend_after.upper = 1'b0;
        end
        else if (s1_pend_reg.row_left)
        begin
            sel_sum             = sum_left;
            sel_cnt             = cnt_left;
            sel_row             = IDX_W'(s1_row_reg);
            sel_col             = IDX_W'(col_m1);
            pend_after.row_left = 1'b0;
        end
        else
        begin
            sel_sum           = sum_corner;
            sel_cnt           = cnt_corner;
            sel_row           = IDX_W'(s1_row_reg);
            sel_col           = IDX_W'(s1_col_reg);
            pend_after.corner = 1'b0;
        end
    end

    // handshake between item, sum stage and divider
    always_comb
    begin
        d_free        = !d_valid_reg || d_ready;
        d_take        = s1_valid_reg && (s1_pend_reg != '0) && d_free;
        s1_pend_next  = d_take ? pend_after : s1_pend_reg;
        retire        = s1_valid_reg && (s1_pend_next == '0);
        in_stall      = s1_valid_reg && !retire;
        s1_valid_next = accept ? 1'b1 : (retire ? 1'b0 : s1_valid_reg);
        if (accept)
        begin
            s1_pend_next = pend;
        end
        d_valid_next  = d_take ? 1'b1 : (d_ready ? 1'b0 : d_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
            d_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_pend_reg  <= s1_pend_next;
            d_valid_reg  <= d_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel;
            s1_flags_reg <= flags;
            s1_row_reg   <= row;
            s1_col_reg   <= col;
        end
    end

    // window slides one column when an item leaves
    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            up_l_reg   <= up_c_reg;
            up_c_reg   <= up_next;
            upup_c_reg <= upup_next;
            cur_ll_reg <= cur_l_reg;
            cur_l_reg  <= s1_pix_reg;
        end
    end

    // sum stage payload
    always_ff @(posedge clk)
    begin
        if (d_take)
        begin
            d_sum_reg  <= sel_sum;
            d_cnt_reg  <= sel_cnt;
            d_row_reg  <= sel_row;
            d_col_reg  <= sel_col;
            d_last_reg <= (pend_after == '0);
        end
    end

    assign d_valid = d_valid_reg;
    assign d_sum   = d_sum_reg;
    assign d_cnt   = d_cnt_reg;
    assign d_row   = d_row_reg;
    assign d_col   = d_col_reg;
    assign d_last  = d_last_reg;

endmodule

/* hw/rtl/cnm_mean_div.sv */
// division of a neighbourhood sum by its count, and the output register
`timescale 1ns / 1ps

module cnm_mean_div
    import cnm_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  d_valid,
    input  logic [PIXEL_BITS+2:0] d_sum,
    input  logic [CNT_W-1:0]      d_cnt,
    input  logic [IDX_W-1:0]      d_row,
    input  logic [IDX_W-1:0]      d_col,
    input  logic                  d_last,
    output logic                  d_ready,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [PIXEL_BITS-1:0] blurred_value,
    output logic [IDX_W-1:0]      out_row,
    output logic [IDX_W-1:0]      out_col,
    output logic                  last_in_run
);

    localparam int SUM_W  = PIXEL_BITS + 3;
    // three guard bits keep the rounded-up reciprocal exact for counts up to 8
    localparam int SHIFT  = SUM_W + 3;
    localparam int MUL_W  = SHIFT + 1;
    localparam int PROD_W = SUM_W + MUL_W;

    localparam logic [MUL_W-1:0] RECIP_1 = MUL_W'(1 << SHIFT);
    localparam logic [MUL_W-1:0] RECIP_2 = MUL_W'(1 << (SHIFT - 1));
    localparam logic [MUL_W-1:0] RECIP_3 = MUL_W'(((1 << SHIFT) + 2) / 3);
    localparam logic [MUL_W-1:0] RECIP_4 = MUL_W'(1 << (SHIFT - 2));
    localparam logic [MUL_W-1:0] RECIP_5 = MUL_W'(((1 << SHIFT) + 4) / 5);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PIXEL_BITS-1:0] blurred_reg;
    logic [IDX_W-1:0]      out_row_reg;
    logic [IDX_W-1:0]      out_col_reg;
    logic                  last_reg;

    logic                  o_free;
    logic                  o_take;
    logic [MUL_W-1:0]      recip;
    logic [PROD_W-1:0]     prod;
    logic [PIXEL_BITS-1:0] quot;

    // reciprocal of the neighbourhood count
    always_comb
    begin
        unique case (d_cnt)
            CNT_W'(2): recip = RECIP_2;
            CNT_W'(3): recip = RECIP_3;
            CNT_W'(4): recip = RECIP_4;
            CNT_W'(5): recip = RECIP_5;
            default:   recip = RECIP_1;
        endcase
    end

    assign prod = PROD_W'(d_sum) * PROD_W'(recip);
    assign quot = prod[SHIFT +: PIXEL_BITS];

    // output handshake
    always_comb
    begin
        o_free         = !out_valid_reg || !out_stall;
        o_take         = d_valid && o_free;
        out_valid_next = o_take ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_take)
        begin
            blurred_reg <= quot;
            out_row_reg <= d_row;
            out_col_reg <= d_col;
            last_reg    <= d_last;
        end
    end

    assign d_ready       = o_free;
    assign out_valid     = out_valid_reg;
    assign blurred_value = blurred_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign last_in_run   = last_reg;

endmodule

/* hw/rtl/cross_neighbourhood_mean_blur_unit.sv */
// top level of the five-point cross mean blur over a square raster image
// path: an item's results pass the item register, the sum stage register and the output register
// throughput: one item per cycle while the output is not stalled; on the last row every item after
//   column 0 owes two results (three at the corner) and holds the input until all have left for the sum stage
// reset: counters, size (8) and all valid flags cleared; the line store is not cleared
`timescale 1ns / 1ps

module cross_neighbourhood_mean_blur_unit
    import cnm_pkg::*;
#(
    parameter int MAX_SIZE   = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // size register write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      image_size,
    // pixel stream in
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    // result stream out
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIXEL_BITS-1:0] blurred_value,
    output logic [IDX_W-1:0]      out_row,
    output logic [IDX_W-1:0]      out_col,
    output logic                  last_in_run
);

    localparam int COL_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SUM_W      = PIXEL_BITS + 3;
    localparam int RESET_LAST = ((RESET_SIZE < MAX_SIZE) ? RESET_SIZE : MAX_SIZE) - 1;

    logic [COL_W-1:0] size_last_reg;
    logic [COL_W-1:0] size_last_next;
    logic [COL_W-1:0] row_reg;
    logic [COL_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    slot_t            slot_reg;
    slot_t            slot_next;

    logic             cfg_fire;
    logic             in_fire;
    logic             col_last;
    logic             row_last;
    pos_flags_t       flags;
    res_mask_t        pend;
    slot_t            rd_slot_a;
    slot_t            rd_slot_b;
    logic [COL_W-1:0] rd_col;

    logic [PIXEL_BITS-1:0] up_next;
    logic [PIXEL_BITS-1:0] upup_next;
    logic                  d_valid;
    logic                  d_ready;
    logic [SUM_W-1:0]      d_sum;
    logic [CNT_W-1:0]      d_cnt;
    logic [IDX_W-1:0]      d_row;
    logic [IDX_W-1:0]      d_col;
    logic                  d_last;

    function automatic slot_t slot_prev(slot_t s);
        slot_t p;
        unique case (s)
            SLOT_W'(0): p = SLOT_W'(ROWS - 1);
            SLOT_W'(1): p = SLOT_W'(0);
            SLOT_W'(2): p = SLOT_W'(1);
            default:    p = SLOT_W'(0);
        endcase
        return p;
    endfunction

    function automatic slot_t slot_succ(slot_t s);
        slot_t n;
        unique case (s)
            SLOT_W'(0): n = SLOT_W'(1);
            SLOT_W'(1): n = SLOT_W'(2);
            default:    n = SLOT_W'(0);
        endcase
        return n;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && !in_stall;

    // size register holds N-1, zero taken as one, large values saturate
    always_comb
    begin
        size_last_next = size_last_reg;
        if (cfg_fire)
        begin
            priority if (image_size == '0)
            begin
                size_last_next = '0;
            end
            else if (32'(image_size) > 32'(MAX_SIZE))
            begin
                size_last_next = COL_W'(MAX_SIZE - 1);
            end
            else
            begin
                size_last_next = COL_W'(image_size - CFG_W'(1));
            end
        end
    end

    // position of the incoming item
    assign col_last = (col_reg == size_last_reg);
    assign row_last = (row_reg == size_last_reg);

    always_comb
    begin
        flags.row_ge1  = (row_reg != '0);
        flags.row_ge2  = (row_reg > COL_W'(1));
        flags.col_ge1  = (col_reg != '0);
        flags.col_ge2  = (col_reg > COL_W'(1));
        flags.col_last = col_last;

        pend.upper    = flags.row_ge1;
        pend.row_left = row_last && flags.col_ge1;
        pend.corner   = row_last && col_last;
    end

    // raster counters, wrap at the end of the image and restart on a size write
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        priority if (cfg_fire)
        begin
            row_next  = '0;
            col_next  = '0;
            slot_next = '0;
        end
        else if (in_fire)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + COL_W'(1);
                    slot_next = slot_succ(slot_reg);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_last_reg <= COL_W'(RESET_LAST);
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            size_last_reg <= size_last_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            slot_reg      <= slot_next;
        end
    end

    // prefetch address: next column of the two rows above, or column 0 for the next row
    always_comb
    begin
        if (col_last)
        begin
            rd_col    = '0;
            rd_slot_a = slot_reg;
            rd_slot_b = slot_prev(slot_reg);
        end
        else
        begin
            rd_col    = col_reg + COL_W'(1);
            rd_slot_a = slot_prev(slot_reg);
            rd_slot_b = slot_prev(slot_prev(slot_reg));
        end
    end

    cnm_line_store #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_SIZE   (MAX_SIZE),
        .COL_W      (COL_W)
    ) u_line_store (
        .clk       (clk),
        .wr_en     (in_fire),
        .wr_slot   (slot_reg),
        .wr_col    (col_reg),
        .wr_data   (pixel_value),
        .rd_en     (in_fire),
        .rd_slot_a (rd_slot_a),
        .rd_slot_b (rd_slot_b),
        .rd_col    (rd_col),
        .rd_data_a (up_next),
        .rd_data_b (upup_next)
    );

    cnm_window #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_fire),
        .pixel     (pixel_value),
        .flags     (flags),
        .row       (row_reg),
        .col       (col_reg),
        .pend      (pend),
        .up_next   (up_next),
        .upup_next (upup_next),
        .in_stall  (in_stall),
        .d_ready   (d_ready),
        .d_valid   (d_valid),
        .d_sum     (d_sum),
        .d_cnt     (d_cnt),
        .d_row     (d_row),
        .d_col     (d_col),
        .d_last    (d_last)
    );

    cnm_mean_div #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mean_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .d_valid       (d_valid),
        .d_sum         (d_sum),
        .d_cnt         (d_cnt),
        .d_row         (d_row),
        .d_col         (d_col),
        .d_last        (d_last),
        .d_ready       (d_ready),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .blurred_value (blurred_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_in_run   (last_in_run)
    );

`ifndef NO_ASSERTIONS
    // raster position never leaves the image
    a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= size_last_reg) && (col_reg <= size_last_reg))
        else $error("raster position outside the image");

    // the first row of an image always lands in line store slot zero
    a_slot_at_top: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg == '0) |-> (slot_reg == '0))
        else $error("line store slot out of step with the row counter");

    // a size write restarts the raster at the top left
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (row_reg == '0) && (col_reg == '0) && (slot_reg == '0))
        else $error("size write did not restart the raster");
`endif

endmodule

/* tb/cross_mean_checker.sv */
// result checker for the cross mean blur: predicts each blurred pixel and compares it on output
`timescale 1ns / 1ps

module cross_mean_checker
    import cnm_pkg::*;
#(
    parameter int MAX_SIZE   = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_W-1:0]      image_size,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [PIXEL_BITS-1:0] blurred_value,
    input  logic [IDX_W-1:0]      out_row,
    input  logic [IDX_W-1:0]      out_col,
    input  logic                  last_in_run,
    output int                    mismatches,
    output int                    pending,
    output int                    results_seen
);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] value;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic                  last;
    } blur_result_t;

    // predicted copy of the three-row line store and the raster position
    logic [PIXEL_BITS-1:0] row_buf [ROWS][MAX_SIZE];
    int unsigned           side;
    int unsigned           row_pos;
    int unsigned           col_pos;
    blur_result_t          owed_results [$];

    // truncated mean over the in-image part of the cross
    function automatic logic [PIXEL_BITS-1:0] cross_mean(int unsigned r, int unsigned c);
        int unsigned sum;
        int unsigned cnt;
        sum = 32'(row_buf[r % ROWS][c]);
        cnt = 1;
        if (r > 0)
        begin
            sum += 32'(row_buf[(r - 1) % ROWS][c]);
            cnt++;
        end
        if (r + 1 < side)
        begin
            sum += 32'(row_buf[(r + 1) % ROWS][c]);
            cnt++;
        end
        if (c > 0)
        begin
            sum += 32'(row_buf[r % ROWS][c - 1]);
            cnt++;
        end
        if (c + 1 < side)
        begin
            sum += 32'(row_buf[r % ROWS][c + 1]);
            cnt++;
        end
        return PIXEL_BITS'(sum / cnt);
    endfunction

    function automatic blur_result_t result_at(int unsigned r, int unsigned c);
        blur_result_t res;
        res.value = cross_mean(r, c);
        res.row   = IDX_W'(r);
        res.col   = IDX_W'(c);
        res.last  = 1'b0;
        return res;
    endfunction

    // size write: zero reads as one, oversize saturates, position restarts
    function automatic void load_size(logic [CFG_W-1:0] v);
        if (v == 0)
            side = 1;
        else if (v > MAX_SIZE)
            side = MAX_SIZE;
        else
            side = 32'(v);
        row_pos = 0;
        col_pos = 0;
    endfunction

    // store one pixel and queue the results it releases
    function automatic void take_pixel(logic [PIXEL_BITS-1:0] v);
        blur_result_t owed [3];
        int           k;
        k = 0;
        row_buf[row_pos % ROWS][col_pos] = v;
        if (row_pos >= 1)
        begin
            owed[k] = result_at(row_pos - 1, col_pos);
            k++;
        end
        // bottom row also releases its own left neighbour, and the corner at the end
        if (row_pos + 1 == side)
        begin
            if (col_pos >= 1)
            begin
                owed[k] = result_at(row_pos, col_pos - 1);
                k++;
            end
            if (col_pos + 1 == side)
            begin
                owed[k] = result_at(row_pos, col_pos);
                k++;
            end
        end
        for (int i = 0; i < k; i++)
        begin
            owed[i].last = (i == k - 1);
            owed_results.push_back(owed[i]);
        end
        // raster advance, wrapping after the last pixel of the image
        if (col_pos + 1 >= side)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= side) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endfunction

    // compare one output item with the oldest prediction
    function automatic void check_result();
        blur_result_t want;
        results_seen++;
        if (owed_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got %0d (%0d,%0d) last %0d",
                     $time, blurred_value, out_row, out_col, last_in_run);
        end
        else
        begin
            want = owed_results.pop_front();
            if (want.value !== blurred_value || want.row !== out_row ||
                want.col !== out_col || want.last !== last_in_run)
            begin
                mismatches++;
                $display("%0t: expected %0d (%0d,%0d) last %0d, got %0d (%0d,%0d) last %0d",
                         $time, want.value, want.row, want.col, want.last,
                         blurred_value, out_row, out_col, last_in_run);
            end
        end
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_results.delete();
            side         = RESET_SIZE;
            row_pos      = 0;
            col_pos      = 0;
            mismatches   = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                load_size(image_size);
            if (in_valid && !in_stall)
                take_pixel(pixel_value);
            if (out_valid && !out_stall)
                check_result();
        end
        pending = owed_results.size();
    end

endmodule

/* tb/tb_cross_neighbourhood_mean_blur_unit.sv */
// testbench top for the cross mean blur: pixel and size stimulus, stall pattern and verdict
`timescale 1ns / 1ps

module tb_cross_neighbourhood_mean_blur_unit;
    import cnm_pkg::*;

    localparam int MAX_SIZE     = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int QUIET_MAX    = 2000;
    localparam int RANDOM_ITEMS = 234;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      image_size  = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [PIXEL_BITS-1:0] pixel_value = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [PIXEL_BITS-1:0] blurred_value;
    logic [IDX_W-1:0]      out_row;
    logic [IDX_W-1:0]      out_col;
    logic                  last_in_run;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          pixels_sent  = 0;
    int          size_writes  = 0;
    int unsigned quiet_cycles = 0;
    int          stall_left   = 0;
    bit          tx_calm      = 1'b0;
    logic        rx_calm      = 1'b0;

    always #1 clk = ~clk;

    cross_neighbourhood_mean_blur_unit #(
        .MAX_SIZE   (MAX_SIZE),
        .PIXEL_BITS (PIXEL_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .image_size    (image_size),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blurred_value (blurred_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_in_run   (last_in_run)
    );

    cross_mean_checker #(
        .MAX_SIZE   (MAX_SIZE),
        .PIXEL_BITS (PIXEL_BITS)
    ) i_checker (.*);

    // output stall: a random hold after each accepted result, none in calm phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
        else if (out_valid && !out_stall)
        begin
            int hold;
            hold = rx_calm ? 0 : $urandom_range(0, 14);
            stall_left <= hold;
            out_stall  <= (hold != 0);
        end
    end

    // watchdog on cycles where no channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == QUIET_MAX)
            begin
                $display("timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
                $display("tb_cross_neighbourhood_mean_blur_unit: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_size(input logic [CFG_W-1:0] v);
        cfg_valid  <= 1'b1;
        image_size <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_writes++;
    endtask

    // one pixel item after a random gap; valid stays high across back-to-back items
    task automatic push_pixel(input logic [PIXEL_BITS-1:0] v);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // wait for every owed result, then let the pipeline empty
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int sz;
        int count;
        int sel;
        int phase;
        int random_items;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size of 8: first row plus one pixel, then a size write mid-image
        for (int i = 0; i < 9; i++)
            push_pixel((i % 2 == 1) ? '1 : '0);
        drain_results();

        // zero size acts as 1x1: every pixel is its own result
        write_size(11'd0);
        push_pixel('0);
        push_pixel('1);
        push_pixel(8'hAA);
        push_pixel(8'h55);
        drain_results();

        // 2x2 at full scale, all corners
        write_size(11'd2);
        repeat (4) push_pixel('1);
        drain_results();

        // 3x3 with a dark centre: divisors 3, 4 and 5 with truncation
        write_size(11'd3);
        for (int i = 0; i < 9; i++)
            push_pixel((i == 4) ? '0 : '1);
        drain_results();

        // random phases, mostly small images; two start an image at the largest size
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase < 6)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                sz    = 2047;
                count = $urandom_range(8, 24);
            end
            else if (phase == 5)
            begin
                sz    = MAX_SIZE;
                count = $urandom_range(8, 24);
            end
            else
            begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    sz = $urandom_range(1, 5);
                else if (sel < 9)
                    sz = $urandom_range(6, 10);
                else
                    sz = $urandom_range(11, 16);
                // some phases stop mid-image so the next size write restarts it
                if ($urandom_range(0, 4) == 0)
                    count = $urandom_range(1, sz * sz);
                else
                    count = sz * sz * $urandom_range(1, 2);
            end
            // keep the run near its item budget
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            if (count < 1)
                count = 1;
            random_items += count;
            write_size(CFG_W'(sz));
            repeat (count) push_pixel(PIXEL_BITS'($urandom_range(0, 255)));
            drain_results();
            phase++;
        end

        repeat (8) @(posedge clk);
        $display("%0d pixels in %0d size settings, sizes 1 to %0d incl. zero and saturated",
                 pixels_sent, size_writes + 1, MAX_SIZE);
        $display("%0d blurred results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb_cross_neighbourhood_mean_blur_unit: clean");
        else
            $display("tb_cross_neighbourhood_mean_blur_unit: errors");
        $finish;
    end

endmodule
